[design/kmgd_pkg.sv]
// Shared constants, codes and beat types for the key matrix debounce block.
`default_nettype none

package kmgd_pkg;

    // Matrix geometry.
    localparam int TOTAL_ROWS = 16;
    localparam int LOCAL_ROWS = 5;
    localparam int ROW_BITS   = 7;
    localparam int ROW_IDX_W  = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;

    // First stable row of each remote block, wrapped to eight bits.
    localparam int REMOTE_BASE_0 = (TOTAL_ROWS - LOCAL_ROWS * 2) & 255;
    localparam int REMOTE_BASE_1 = (TOTAL_ROWS - LOCAL_ROWS * 3) & 255;

    localparam logic [15:0] TICK_TOP       = 16'hFFFF;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;

    // Item kinds carried in tuser.
    localparam logic [2:0] KIND_SCAN   = 3'd0;
    localparam logic [2:0] KIND_TICK   = 3'd1;
    localparam logic [2:0] KIND_EOS    = 3'd2;
    localparam logic [2:0] KIND_REMOTE = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;

    // Configuration register word indexes.
    localparam logic CFG_IDX_DEBOUNCE = 1'b0;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] row_index;
        logic [2:0] col_index;
        logic [6:0] row_bits;
        logic       remote_index;
    } item_t;

    typedef struct packed {
        logic [6:0] stable_row;
        logic       key_on;
        logic       debounce_pending;
        logic       committed;
    } result_t;

endpackage

`default_nettype wire

[design/key_matrix_global_debounce.sv]
// Key matrix with one global debounce timer: input register, core and APB port.
//
// Usage: items arrive on the s_ stream. s_tuser carries the kind (scanned row,
// millisecond tick, end of scan, remote row write, read) and s_tdata the row,
// column, row bits and remote block select. Every accepted beat yields exactly
// one result beat on the m_ stream with the stable row and key bit of a read,
// the pending flag after the item and a commit marker.
// A taken beat sits in the input register, is processed against the matrix
// stores and is written to the result register once that register is free.
// Throughput is one item per cycle while the receiver takes results; every item
// is handled by a single pass of logic between the input and result registers.
// If the receiver holds m_tready low, the result register keeps its beat, the
// input register still takes one more beat, and then s_tready drops until the
// result is taken.
// The APB port holds debounce_ticks at word 0; the user must write it only while the
// streams are idle, which the block does not enforce. A synchronous active-low reset
// clears both matrices, pending flag and quiet counter, and loads the threshold with 5.
`default_nettype none

module key_matrix_global_debounce
    import kmgd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: row_index[3:0], col_index[6:4], row_bits[13:7], remote_index[14], zero[15]
    input  wire logic [15:0] s_tdata,
    // s_tuser: kind[2:0]
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: stable_row[6:0], key_on[7], debounce_pending[8], committed[9], zero[15:10]
    output logic      [15:0] m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    logic       s_fire;
    logic       core_ready;
    logic       core_take;
    logic [7:0] debounce_ticks;
    result_t    res;

    assign s_tready  = !in_valid_reg || core_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign core_take = in_valid_reg && core_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (core_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.row_index    <= s_tdata[3:0];
            in_item_reg.col_index    <= s_tdata[6:4];
            in_item_reg.row_bits     <= s_tdata[13:7];
            in_item_reg.remote_index <= s_tdata[14];
        end
    end

    kmgd_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .debounce_ticks (debounce_ticks)
    );

    kmgd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .debounce_ticks (debounce_ticks),
        .item_valid     (in_valid_reg),
        .item           (in_item_reg),
        .item_ready     (core_ready),
        .res_valid      (m_tvalid),
        .res            (res),
        .res_ready      (m_tready)
    );

    assign m_tdata = {6'd0, res.committed, res.debounce_pending, res.key_on, res.stable_row};

endmodule

`default_nettype wire

[design/kmgd_cfg.sv]
// APB configuration register holding the debounce threshold.
`default_nettype none

module kmgd_cfg
    import kmgd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  debounce_ticks
);

    logic [7:0] debounce_reg;
    logic [7:0] debounce_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // The word index is paddr[2]; the byte offset bits are ignored.
    always_comb begin
        debounce_next = debounce_reg;
        if (wr_en && (paddr[2] == CFG_IDX_DEBOUNCE)) begin
            debounce_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else begin
            debounce_reg <= debounce_next;
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == CFG_IDX_DEBOUNCE) begin
            prdata = {24'd0, debounce_reg};
        end
    end

    assign debounce_ticks = debounce_reg;

endmodule

`default_nettype wire

[design/kmgd_core.sv]
// Pending and stable matrix stores, debounce timer and the result register.
`default_nettype none

module kmgd_core
    import kmgd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] debounce_ticks,
    input  wire logic       item_valid,
    input  wire item_t      item,
    output logic            item_ready,
    output logic            res_valid,
    output result_t         res,
    input  wire logic       res_ready
);

    logic [ROW_BITS-1:0] stable_reg  [TOTAL_ROWS];
    logic [ROW_BITS-1:0] stable_next [TOTAL_ROWS];
    logic [ROW_BITS-1:0] pending_reg  [TOTAL_ROWS];
    logic [ROW_BITS-1:0] pending_next [TOTAL_ROWS];
    logic                change_reg;
    logic                change_next;
    logic [15:0]         quiet_reg;
    logic [15:0]         quiet_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             result_reg;
    result_t             result_next;

    logic                fire;
    logic [7:0]          row_ext;
    logic                row_hit;
    logic [ROW_IDX_W-1:0] row_sel;
    logic [31:0]         sample32;
    logic [ROW_BITS-1:0] sample;
    logic [31:0]         remote32;
    logic [8:0]          remote_base;
    logic [8:0]          remote_target;
    logic                remote_hit;
    logic [ROW_IDX_W-1:0] remote_sel;
    logic [31:0]         rd_word32;
    logic [31:0]         rd_shifted;
    logic                commit_ok;

    assign item_ready = !out_valid_reg || res_ready;
    assign fire       = item_valid && item_ready;

    assign row_ext  = {4'd0, item.row_index};
    assign row_hit  = 32'(row_ext) < TOTAL_ROWS;
    assign row_sel  = row_ext[ROW_IDX_W-1:0];

    // The raw sample is active low; bits above the field invert to ones.
    assign sample32 = ~{25'd0, item.row_bits};
    assign sample   = sample32[ROW_BITS-1:0];
    assign remote32 = {25'd0, item.row_bits};

    assign remote_base   = item.remote_index ? 9'(REMOTE_BASE_1) : 9'(REMOTE_BASE_0);
    assign remote_target = remote_base + {5'd0, item.row_index};
    assign remote_hit    = (32'(row_ext) < LOCAL_ROWS)
                        && (32'(remote_target) < TOTAL_ROWS);
    assign remote_sel    = remote_target[ROW_IDX_W-1:0];

    assign rd_word32  = 32'(stable_reg[row_sel]);
    assign rd_shifted = rd_word32 >> item.col_index;

    assign commit_ok = change_reg && (quiet_reg > {8'd0, debounce_ticks});

    always_comb begin
        stable_next    = stable_reg;
        pending_next   = pending_reg;
        change_next    = change_reg;
        quiet_next     = quiet_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (res_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            result_next = '0;
            case (item.kind)
                KIND_SCAN: begin
                    if (row_hit && (pending_reg[row_sel] != sample)) begin
                        pending_next[row_sel] = sample;
                        change_next           = 1'b1;
                        quiet_next            = 16'd0;
                    end
                end
                KIND_TICK: begin
                    if (quiet_reg != TICK_TOP) begin
                        quiet_next = quiet_reg + 16'd1;
                    end
                end
                KIND_EOS: begin
                    if (commit_ok) begin
                        stable_next           = pending_reg;
                        change_next           = 1'b0;
                        result_next.committed = 1'b1;
                    end
                end
                KIND_REMOTE: begin
                    if (remote_hit) begin
                        stable_next[remote_sel] = remote32[ROW_BITS-1:0];
                    end
                end
                KIND_READ: begin
                    if (row_hit) begin
                        result_next.stable_row = rd_word32[6:0];
                        result_next.key_on     = (32'(item.col_index) < ROW_BITS)
                                              && rd_shifted[0];
                    end
                end
                default: begin
                end
            endcase
            result_next.debounce_pending = change_next;
            out_valid_next               = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_ROWS; i++) begin
                stable_reg[i]  <= '0;
                pending_reg[i] <= '0;
            end
            change_reg    <= 1'b0;
            quiet_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end else begin
            stable_reg    <= stable_next;
            pending_reg   <= pending_next;
            change_reg    <= change_next;
            quiet_reg     <= quiet_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = result_reg;

    // A commit always leaves the pending flag clear in the same beat.
    a_commit_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.committed |-> !result_reg.debounce_pending)
        else $error("commit beat reports a pending change");

    // The reported flag matches the internal flag until the next item is taken.
    a_flag_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire |=> result_reg.debounce_pending == change_reg)
        else $error("result flag differs from pending state");

    // A tick below saturation advances the quiet counter by exactly one.
    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && fire && (item.kind == KIND_TICK) && (quiet_reg != TICK_TOP)
        |=> quiet_reg == $past(quiet_reg) + 16'd1)
        else $error("quiet counter did not advance on tick");

endmodule

`default_nettype wire

[bench/tb.sv]
// Testbench for key_matrix_global_debounce: directed and random beats checked against a predictor.
module tb;
    import kmgd_pkg::*;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [2:0] ADDR_DEBOUNCE    = {CFG_IDX_DEBOUNCE, 2'b00};
    localparam int         SETTLE_CYCLES    = 4;
    localparam int         REPORT_LIMIT     = 100;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    // s_tdata: row_index[3:0], col_index[6:4], row_bits[13:7], remote_index[14], zero[15]
    logic [15:0] s_tdata  = '0;
    // s_tuser: kind[2:0]
    logic [2:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // m_tdata: stable_row[6:0], key_on[7], debounce_pending[8], committed[9], zero[15:10]
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted state of the block.
    logic [6:0]  stable_copy [TOTAL_ROWS];
    logic [6:0]  pending_copy [TOTAL_ROWS];
    logic        change_flag;
    logic [15:0] quiet_count;
    logic [7:0]  debounce_limit;
    result_t     matrix_replies [$];

    // Raw active-low level of each row as the scanner currently sees it.
    logic [6:0]  scan_raw [TOTAL_ROWS];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    key_matrix_global_debounce i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic result_t advance_matrix(input item_t it);
        result_t    r;
        logic [6:0] sample;
        logic [7:0] base;
        logic [8:0] target;
        r = '0;
        case (it.kind)
            KIND_SCAN: begin
                if (it.row_index < TOTAL_ROWS) begin
                    sample = ~it.row_bits;
                    if (pending_copy[it.row_index] != sample) begin
                        pending_copy[it.row_index] = sample;
                        change_flag = 1'b1;
                        quiet_count = '0;
                    end
                end
            end
            KIND_TICK: begin
                if (quiet_count != TICK_TOP) quiet_count = quiet_count + 16'd1;
            end
            KIND_EOS: begin
                if (change_flag && quiet_count > debounce_limit) begin
                    for (int i = 0; i < TOTAL_ROWS; i++) stable_copy[i] = pending_copy[i];
                    change_flag = 1'b0;
                    r.committed = 1'b1;
                end
            end
            KIND_REMOTE: begin
                if (it.row_index < LOCAL_ROWS) begin
                    // The block offset wraps at eight bits before the row is added.
                    base = 8'(TOTAL_ROWS - LOCAL_ROWS * (int'(it.remote_index) + 2));
                    target = {1'b0, base} + it.row_index;
                    if (target < TOTAL_ROWS) stable_copy[target[3:0]] = it.row_bits;
                end
            end
            KIND_READ: begin
                if (it.row_index < TOTAL_ROWS) begin
                    r.stable_row = stable_copy[it.row_index];
                    if (it.col_index < ROW_BITS) begin
                        r.key_on = stable_copy[it.row_index][it.col_index];
                    end
                end
            end
            default: begin
            end
        endcase
        r.debounce_pending = change_flag;
        return r;
    endfunction

    function automatic item_t make_item(input logic [2:0] kind, input logic [3:0] row,
                                        input logic [2:0] col, input logic [6:0] bits,
                                        input logic sel);
        item_t it;
        it.kind         = kind;
        it.row_index    = row;
        it.col_index    = col;
        it.row_bits     = bits;
        it.remote_index = sel;
        return it;
    endfunction

    function automatic item_t random_item(input logic [2:0] kind);
        return make_item(kind, 4'($urandom), 3'($urandom), 7'($urandom), 1'($urandom));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {1'b0, it.remote_index, it.row_bits, it.col_index, it.row_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        matrix_replies.push_back(advance_matrix(it));
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (matrix_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_debounce(input logic [7:0] value);
        wait_until_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEBOUNCE;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        debounce_limit = value;
    endtask

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (matrix_replies.size() == 0) begin
                report_mismatch("unexpected result beat", int'(m_tdata), 0);
            end else begin
                want = matrix_replies.pop_front();
                if (m_tdata[6:0] != want.stable_row)
                    report_mismatch("stable_row", int'(m_tdata[6:0]), int'(want.stable_row));
                if (m_tdata[7] != want.key_on)
                    report_mismatch("key_on", int'(m_tdata[7]), int'(want.key_on));
                if (m_tdata[8] != want.debounce_pending)
                    report_mismatch("debounce_pending", int'(m_tdata[8]),
                                    int'(want.debounce_pending));
                if (m_tdata[9] != want.committed)
                    report_mismatch("committed", int'(m_tdata[9]), int'(want.committed));
                if (m_tdata[15:10] != '0)
                    report_mismatch("m_tdata padding", int'(m_tdata[15:10]), 0);
            end
        end
    end

    // Field extremes, spare kinds, both remote blocks and reads around the edges.
    task automatic check_fields();
        send_item(make_item(KIND_READ, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd15, 3'd6, 7'h7F, 1'b1));
        send_item(make_item(KIND_SCAN, 4'd0, 3'd0, 7'h00, 1'b0));
        // All keys released matches the cleared pending row, so nothing changes.
        send_item(make_item(KIND_SCAN, 4'd15, 3'd7, 7'h7F, 1'b1));
        send_item(make_item(KIND_SCAN, 4'd15, 3'd0, 7'h55, 1'b0));
        for (int k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++) begin
            send_item(make_item(3'(k), 4'd15, 3'd7, 7'h7F, 1'b1));
        end
        send_item(make_item(KIND_REMOTE, 4'd0, 3'd0, 7'h7F, 1'b0));
        send_item(make_item(KIND_REMOTE, 4'd4, 3'd7, 7'h2A, 1'b0));
        send_item(make_item(KIND_REMOTE, 4'd0, 3'd0, 7'h7F, 1'b1));
        send_item(make_item(KIND_REMOTE, 4'd4, 3'd0, 7'h01, 1'b1));
        send_item(make_item(KIND_REMOTE, 4'd5, 3'd0, 7'h7F, 1'b0));
        send_item(make_item(KIND_REMOTE, 4'd15, 3'd0, 7'h7F, 1'b1));
        send_item(make_item(KIND_READ, 4'd1, 3'd6, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd5, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd6, 3'd6, 7'h00, 1'b1));
        send_item(make_item(KIND_READ, 4'd10, 3'd1, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd6, 3'd7, 7'h7F, 1'b0));
        send_item(make_item(KIND_READ, 4'd11, 3'd0, 7'h00, 1'b0));
    endtask

    // With a zero threshold a single quiet tick is enough to commit.
    task automatic check_commit();
        set_debounce(8'd0);
        send_item(make_item(KIND_SCAN, 4'd3, 3'd0, 7'h0F, 1'b0));
        send_item(make_item(KIND_EOS, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_TICK, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_EOS, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_EOS, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd3, 3'd4, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd0, 3'd6, 7'h00, 1'b0));
    endtask

    // The largest threshold still commits once the quiet count runs past it.
    task automatic check_long_quiet();
        set_debounce(8'd255);
        send_item(make_item(KIND_SCAN, 4'd7, 3'd0, 7'h3C, 1'b0));
        repeat (255 + 5) send_item(random_item(KIND_TICK));
        send_item(make_item(KIND_EOS, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_READ, 4'd7, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_SCAN, 4'd7, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_TICK, 4'd0, 3'd0, 7'h00, 1'b0));
        send_item(make_item(KIND_EOS, 4'd0, 3'd0, 7'h00, 1'b0));
    endtask

    // Mostly whole scan frames with random key changes, some random noise between.
    task automatic run_frames(input int budget);
        int sent;
        int ticks;
        int extra;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 85) begin
                for (int r = 0; r < TOTAL_ROWS; r++) begin
                    if ($urandom_range(99) < 8) scan_raw[r][$urandom_range(ROW_BITS - 1)] ^= 1'b1;
                    send_item(make_item(KIND_SCAN, 4'(r), 3'($urandom), scan_raw[r],
                                        1'($urandom)));
                end
                ticks = $urandom_range(int'(debounce_limit) + 4);
                repeat (ticks) send_item(random_item(KIND_TICK));
                send_item(random_item(KIND_EOS));
                extra = $urandom_range(4);
                repeat (extra) begin
                    if ($urandom_range(3) == 0) begin
                        send_item(make_item(KIND_REMOTE, 4'($urandom_range(7)), 3'($urandom),
                                            7'($urandom), 1'($urandom)));
                    end else begin
                        send_item(random_item(KIND_READ));
                    end
                end
                sent += TOTAL_ROWS + ticks + 1 + extra;
            end else begin
                repeat (6) send_item(random_item(3'($urandom)));
                sent += 6;
            end
        end
    endtask

    // A long receiver stall fills the block; then the sender waits for it to drain.
    task automatic check_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 60;
        repeat (40) send_item(random_item(3'($urandom_range(4))));
        wait_until_idle();
        repeat (10) send_item(random_item(3'($urandom_range(4))));
    endtask

    initial begin
        for (int i = 0; i < TOTAL_ROWS; i++) begin
            stable_copy[i]  = '0;
            pending_copy[i] = '0;
            scan_raw[i]     = 7'h7F;
        end
        change_flag    = 1'b0;
        quiet_count    = '0;
        debounce_limit = DEBOUNCE_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_fields();
        check_commit();
        check_long_quiet();

        set_debounce(8'd3);
        send_idle_pct = 6;
        recv_idle_pct = 51;
        run_frames(220);

        set_debounce(8'($urandom_range(1, 12)));
        send_idle_pct = 51;
        recv_idle_pct = 6;
        run_frames(220);

        set_debounce(DEBOUNCE_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_frames(200);

        check_backpressure();
        wait_until_idle();

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
